// ----- design/tuuid_pkg.sv -----
// Package for the time-based UUID generator.
// Holds the request and identifier transaction types and the fixed constants.
// No dependencies.
`default_nettype none

package tuuid_pkg;

  // Request transaction
  typedef struct packed {
    logic [6:0]  count;
    logic [36:0] seconds;
    logic [29:0] nanoseconds;
    logic [47:0] mac_address;
    logic [15:0] random_seq;
  } in_t;

  // Identifier transaction
  typedef struct packed {
    logic [31:0] tick_low;
    logic [15:0] tick_mid;
    logic [15:0] time_hi_version;
    logic [7:0]  clock_seq_hi;
    logic [7:0]  seq_low;
    logic [47:0] node_out;
    logic        last_of_batch;
  } out_t;

  localparam int unsigned TickW = 60;
  localparam int unsigned SeqW  = 14;
  localparam int unsigned NodeW = 48;

  // Ticks from 1582-10-15 to 1970-01-01, in 100 ns units
  localparam logic [TickW-1:0] EpochOffset = 60'h01B21DD213814000;
  localparam logic [23:0]      TicksPerSec = 24'd10000000;
  localparam logic [7:0]       NsPerTick   = 8'd100;

  localparam logic [4:0] MulLastStep = 5'd23;  // top bit index of TicksPerSec

  // ns / 100 = ((ns >> 2) * DivRecip) >> 33, exact for 30-bit ns
  localparam logic [28:0] DivRecip = 29'h147AE148;  // 2^33 / 25, rounded up

  localparam logic [3:0]       VersionCode = 4'h1;
  localparam logic [1:0]       VariantCode = 2'b10;
  localparam logic [NodeW-1:0] McastBit    = 48'h01_0000_0000_00;

endpackage

`default_nettype wire

// ----- design/time_based_uuid_generator_core.sv -----
// Version-1 UUID generator: turns a wall-time request into a batch of identifiers.
// One shared 60-bit adder, a reciprocal multiply for the divide by 100 and a step sequencer.
// Depends on tuuid_pkg.
//
// Steps: 24 multiply steps, one reciprocal multiply, one add and one sequence
// decision run from request to first identifier, mostly the shared adder stepping
// through the bits of the ticks-per-second constant; then one identifier per cycle
// while the output does not stall. The block takes no new request until the whole
// batch has been emitted.
// Reset clears the stored tick, node and sequence (no history) and idles.
`default_nettype none

module time_based_uuid_generator_core #(
  parameter int unsigned MAX_BATCH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire tuuid_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output tuuid_pkg::out_t       out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_BATCH + 1);
  localparam int unsigned TickW = tuuid_pkg::TickW;
  localparam int unsigned SeqW = tuuid_pkg::SeqW;
  localparam int unsigned NodeW = tuuid_pkg::NodeW;

  // Sequencer codes
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StMul    = 3'd1;
  localparam logic [2:0] StDiv    = 3'd2;
  localparam logic [2:0] StAddQ   = 3'd3;
  localparam logic [2:0] StDecide = 3'd4;
  localparam logic [2:0] StEmit   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [4:0]       step_q, step_d;
  logic [CntW-1:0]  left_q, left_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [36:0]      sec_q, sec_d;
  logic [29:0]      ns_q, ns_d;      // nanoseconds, becomes quotient
  logic [NodeW-1:0] node_q, node_d;
  logic [15:0]      rnd_q, rnd_d;
  logic [SeqW-1:0]  seq_q, seq_d;

  logic [TickW-1:0] last_tick_q, last_tick_d;
  logic [NodeW-1:0] last_node_q, last_node_d;
  logic [SeqW-1:0]  last_seq_q, last_seq_d;

  logic             in_fire, out_fire;
  logic [TickW-1:0] add_b, add_sum, sec_shift;
  logic [56:0]      div_prod;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  // Shared adder and its operand select
  assign sec_shift = {{(TickW-37){1'b0}}, sec_q} << step_q;

  always_comb begin
    add_b = '0;
    unique case (state_q)
      StMul: begin
        if (tuuid_pkg::TicksPerSec[step_q]) add_b = sec_shift;
      end
      StAddQ:  add_b = {{(TickW-30){1'b0}}, ns_q};
      StEmit:  add_b = {{(TickW-1){1'b0}}, 1'b1};
      default: add_b = '0;
    endcase
  end

  assign add_sum = tick_q + add_b;

  // Divide by 100 as a divide by 4 then a reciprocal multiply by 1/25
  assign div_prod = {29'd0, ns_q[29:2]} * {28'd0, tuuid_pkg::DivRecip};

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    left_d      = left_q;
    tick_d      = tick_q;
    sec_d       = sec_q;
    ns_d        = ns_q;
    node_d      = node_q;
    rnd_d       = rnd_q;
    seq_d       = seq_q;
    last_tick_d = last_tick_q;
    last_node_d = last_node_q;
    last_seq_d  = last_seq_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire && (in_data_i.count != '0)) begin
          if (32'(in_data_i.count) > MAX_BATCH) left_d = CntW'(MAX_BATCH);
          else left_d = CntW'(in_data_i.count);
          sec_d   = in_data_i.seconds;
          ns_d    = in_data_i.nanoseconds;
          node_d  = in_data_i.mac_address | tuuid_pkg::McastBit;
          rnd_d   = in_data_i.random_seq;
          tick_d  = tuuid_pkg::EpochOffset;
          step_d  = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        tick_d = add_sum;
        if (step_q == tuuid_pkg::MulLastStep) begin
          step_d  = '0;
          state_d = StDiv;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      StDiv: begin
        ns_d    = {6'd0, div_prod[56:33]};
        state_d = StAddQ;
      end
      StAddQ: begin
        tick_d  = add_sum;
        state_d = StDecide;
      end
      StDecide: begin
        // Clock sequence: restart, bump on non-advancing time, or keep
        if ((last_tick_q == '0) || (last_node_q != node_q)) seq_d = rnd_q[SeqW-1:0];
        else if (last_tick_q >= tick_q) seq_d = last_seq_q + SeqW'(1);
        else seq_d = last_seq_q;
        last_seq_d  = seq_d;
        last_node_d = node_q;
        state_d     = StEmit;
      end
      StEmit: begin
        if (out_fire) begin
          if (left_q == CntW'(1)) begin
            last_tick_d = tick_q;
            state_d     = StIdle;
          end else begin
            tick_d = add_sum;
            left_d = left_q - CntW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      left_q      <= '0;
      last_tick_q <= '0;
      last_node_q <= '0;
      last_seq_q  <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      left_q      <= left_d;
      last_tick_q <= last_tick_d;
      last_node_q <= last_node_d;
      last_seq_q  <= last_seq_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    tick_q <= tick_d;
    sec_q  <= sec_d;
    ns_q   <= ns_d;
    node_q <= node_d;
    rnd_q  <= rnd_d;
    seq_q  <= seq_d;
  end

  // Ports
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StEmit);

  always_comb begin
    out_data_o.tick_low        = tick_q[31:0];
    out_data_o.tick_mid        = tick_q[47:32];
    out_data_o.time_hi_version = {tuuid_pkg::VersionCode, tick_q[59:48]};
    out_data_o.clock_seq_hi    = {tuuid_pkg::VariantCode, seq_q[13:8]};
    out_data_o.seq_low         = seq_q[7:0];
    out_data_o.node_out        = node_q;
    out_data_o.last_of_batch   = (left_q == CntW'(1));
  end

endmodule

`default_nettype wire
